// ----- src/framed_command_station_macros.svh -----
// Assertion macros used by the port-level checker file.
`ifndef FRAMED_COMMAND_STATION_MACROS_SVH
`define FRAMED_COMMAND_STATION_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FCS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define FCS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- src/fcs_pkg.sv -----
// Shared types, constants and the CRC step for the framed command station.
package fcs_pkg;

	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_LEN  = 3'd1;
	localparam logic [2:0] PH_CMD  = 3'd2;
	localparam logic [2:0] PH_PAY  = 3'd3;
	localparam logic [2:0] PH_CHI  = 3'd4;
	localparam logic [2:0] PH_CLO  = 3'd5;

	localparam logic [7:0]  SOF_BYTE    = 8'hAA;
	localparam logic [7:0]  RSP_BIT     = 8'h80;
	localparam logic [7:0]  NAK_CMD     = 8'h7F;
	localparam logic [15:0] CRC_POLY    = 16'h1021;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [7:0]  MAX_PAYLOAD = 8'd32;

	localparam logic [7:0] CMD_HELLO = 8'h01;
	localparam logic [7:0] CMD_READ  = 8'h02;
	localparam logic [7:0] CMD_RATE  = 8'h03;
	localparam logic [7:0] CMD_STATS = 8'h04;

	localparam logic [16:0] ALPHA_RST   = 17'd16384;
	localparam logic [7:0]  RATE_RST    = 8'd10;
	localparam logic [11:0] ADC_FULL_MV = 12'd3300;
	localparam logic [12:0] ADC_MAX     = 13'd4095;
	localparam logic [51:0] ROUND_HALF  = 52'd32768;
	localparam logic        DIV_LAST    = 1'b1;

	typedef struct packed {
		logic take_byte;
		logic take_sample;
		logic div_fold;
		logic div_fix;
		logic diff;
		logic mul_lo;
		logic mul_hi;
		logic acc;
		logic emit_load;
	} fcs_cmd_t;

	typedef struct packed {
		logic reply_pend;
		logic out_free;
		logic emit_last;
	} fcs_stat_t;

	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

// ----- src/framed_command_station.sv -----
// Top level of the framed command station.
// Usage:
//   Input stream s_*: each beat is a received serial byte (s_tuser 0, byte in
//   s_tdata[7:0]) or an ADC sample (s_tuser 1, reading in s_tdata[19:8]).
//   Output stream m_*: reply frame bytes, m_tlast on the low CRC byte.
//   cfg_we/cfg_wdata write the EMA weight (unsigned Q1.16); write only while idle.
// Sequencing:
//   A byte beat passes the accept and a post state; a frame-closing byte with
//   a good CRC then emits 5 to 9 reply bytes, one per cycle while m_tready is
//   high. A sample beat runs through the accept, two folding steps of the
//   divide by 4095, the difference, two partial products of the EMA weight
//   and the accumulate.
//   One beat is in work at a time; s_tready is low while it runs.
// Reset:
//   arst_n clears the parser to hunting, counters and filter to zero, the
//   weight to 0.25 and the rate setting to ten.
// Stall:
//   The reply byte register holds while m_tready is low and the next byte
//   waits; a new input beat is taken once the last reply byte is loaded.
module framed_command_station (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // rx_byte[7:0], adc_sample[19:8], zero[23:20]
	input  logic        s_tuser,   // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // tx_byte[7:0]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [16:0] cfg_wdata
);

	fcs_pkg::fcs_cmd_t  cmd;
	fcs_pkg::fcs_stat_t stat;

	fcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	fcs_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.rx_byte    (s_tdata[7:0]),
		.adc_sample (s_tdata[19:8]),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.m_tready   (m_tready),
		.m_tvalid   (m_tvalid),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

// ----- src/fcs_ctrl.sv -----
// Controller state machine: sequences parsing, filter update and reply emission.
module fcs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tuser,
	output logic               s_tready,
	input  fcs_pkg::fcs_stat_t stat,
	output fcs_pkg::fcs_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_POST   = 3'd1;
	localparam logic [2:0] ST_DIV    = 3'd2;
	localparam logic [2:0] ST_DIFF   = 3'd3;
	localparam logic [2:0] ST_MUL_LO = 3'd4;
	localparam logic [2:0] ST_MUL_HI = 3'd5;
	localparam logic [2:0] ST_ACC    = 3'd6;
	localparam logic [2:0] ST_EMIT   = 3'd7;

	logic [2:0] state_q;
	logic       div_cnt_q;
	logic       accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd             = '0;
		cmd.take_byte   = accept && !s_tuser;
		cmd.take_sample = accept && s_tuser;
		cmd.div_fold    = (state_q == ST_DIV) && (div_cnt_q != fcs_pkg::DIV_LAST);
		cmd.div_fix     = (state_q == ST_DIV) && (div_cnt_q == fcs_pkg::DIV_LAST);
		cmd.diff        = (state_q == ST_DIFF);
		cmd.mul_lo      = (state_q == ST_MUL_LO);
		cmd.mul_hi      = (state_q == ST_MUL_HI);
		cmd.acc         = (state_q == ST_ACC);
		cmd.emit_load   = (state_q == ST_EMIT) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			div_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					div_cnt_q <= '0;
					if (accept) begin
						state_q <= s_tuser ? ST_DIV : ST_POST;
					end
				end
				ST_POST: begin
					state_q <= stat.reply_pend ? ST_EMIT : ST_IDLE;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == fcs_pkg::DIV_LAST) begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF:   state_q <= ST_MUL_LO;
				ST_MUL_LO: state_q <= ST_MUL_HI;
				ST_MUL_HI: state_q <= ST_ACC;
				ST_ACC:    state_q <= ST_IDLE;
				ST_EMIT: begin
					if (stat.out_free && stat.emit_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- src/fcs_dp.sv -----
// Datapath: frame parser, counters, EMA filter arithmetic and reply byte output.
module fcs_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  fcs_pkg::fcs_cmd_t  cmd,
	output fcs_pkg::fcs_stat_t stat,
	input  logic [7:0]         rx_byte,
	input  logic [11:0]        adc_sample,
	input  logic               cfg_we,
	input  logic [16:0]        cfg_wdata,
	input  logic               m_tready,
	output logic               m_tvalid,
	output logic [7:0]         m_tdata,
	output logic               m_tlast
);

	logic [16:0] alpha_q;
	logic [2:0]  phase_q;
	logic [5:0]  flen_q;
	logic [7:0]  fcmd_q;
	logic [5:0]  seen_q;
	logic [7:0]  first_q;
	logic [15:0] crc_q;
	logic [7:0]  chk_hi_q;
	logic [15:0] bad_cnt_q;
	logic [15:0] unk_cnt_q;
	logic [7:0]  rate_q;
	logic [31:0] filt_q;

	logic        pend_q;
	logic [7:0]  rcmd_q;
	logic [2:0]  rlen_q;
	logic [7:0]  rpay_q [4];
	logic [3:0]  idx_q;
	logic [15:0] txcrc_q;
	logic        tvalid_q;
	logic [7:0]  tdata_q;
	logic        tlast_q;

	logic [27:0] num_q;
	logic [16:0] rem_q;
	logic [27:0] quot_q;
	logic signed [33:0] diff_q;
	logic signed [51:0] acc_q;

	logic [15:0] crc_nxt;
	logic [5:0]  seen_nxt;
	logic [32:0] mv_sum;
	logic [16:0] mv_raw;
	logic [15:0] mv;
	logic [16:0] fold1;
	logic [4:0]  fold_hi;
	logic [12:0] fold2;
	logic        fold_ge;
	logic [23:0] adc_mv;
	logic signed [17:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [35:0] prod;
	logic [51:0] acc_rnd;
	logic [3:0]  pay_end;
	logic [3:0]  pay_off;
	logic [7:0]  emit_byte;

	assign crc_nxt  = fcs_pkg::crc_step(crc_q, rx_byte);
	assign seen_nxt = seen_q + 6'd1;

	assign mv_sum = {filt_q[31], filt_q} + 33'd32768;
	assign mv_raw = mv_sum[32:16];
	assign mv     = (!mv_raw[16] && mv_raw[15]) ? 16'h7FFF : mv_raw[15:0];

	assign adc_mv  = 24'(adc_sample) * 24'(fcs_pkg::ADC_FULL_MV);
	assign fold1   = 17'(num_q[11:0]) + 17'(num_q[27:12]);
	assign fold_hi = rem_q[16:12];
	assign fold2   = 13'(rem_q[11:0]) + 13'(fold_hi);
	assign fold_ge = (fold2 >= fcs_pkg::ADC_MAX);

	assign mul_a = $signed({1'b0, alpha_q});
	assign mul_b = cmd.mul_hi ? $signed({diff_q[33], diff_q[33:17]})
	                          : $signed({1'b0, diff_q[16:0]});
	assign prod  = mul_a * mul_b;
	assign acc_rnd = 52'(acc_q) + fcs_pkg::ROUND_HALF;

	assign pay_end = {1'b0, rlen_q} + 4'd3;
	assign pay_off = idx_q - 4'd3;

	always_comb begin
		if (idx_q == 4'd0) begin
			emit_byte = fcs_pkg::SOF_BYTE;
		end else if (idx_q == 4'd1) begin
			emit_byte = {5'd0, rlen_q};
		end else if (idx_q == 4'd2) begin
			emit_byte = rcmd_q;
		end else if (idx_q < pay_end) begin
			emit_byte = rpay_q[pay_off[1:0]];
		end else if (idx_q == pay_end) begin
			emit_byte = txcrc_q[15:8];
		end else begin
			emit_byte = txcrc_q[7:0];
		end
	end

	assign stat.reply_pend = pend_q;
	assign stat.out_free   = !tvalid_q || m_tready;
	assign stat.emit_last  = (idx_q == pay_end + 4'd1);

	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;
	assign m_tlast  = tlast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q   <= fcs_pkg::ALPHA_RST;
			phase_q   <= fcs_pkg::PH_HUNT;
			flen_q    <= '0;
			fcmd_q    <= '0;
			seen_q    <= '0;
			first_q   <= '0;
			crc_q     <= '0;
			chk_hi_q  <= '0;
			bad_cnt_q <= '0;
			unk_cnt_q <= '0;
			rate_q    <= fcs_pkg::RATE_RST;
			filt_q    <= '0;
			pend_q    <= 1'b0;
			idx_q     <= '0;
			tvalid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				alpha_q <= cfg_wdata;
			end
			if (cmd.take_byte) begin
				case (phase_q)
					fcs_pkg::PH_LEN: begin
						if (rx_byte > fcs_pkg::MAX_PAYLOAD) begin
							phase_q <= fcs_pkg::PH_HUNT;
						end else begin
							flen_q  <= rx_byte[5:0];
							seen_q  <= '0;
							crc_q   <= fcs_pkg::crc_step(fcs_pkg::CRC_INIT, rx_byte);
							phase_q <= fcs_pkg::PH_CMD;
						end
					end
					fcs_pkg::PH_CMD: begin
						fcmd_q  <= rx_byte;
						crc_q   <= crc_nxt;
						phase_q <= (flen_q != 6'd0) ? fcs_pkg::PH_PAY : fcs_pkg::PH_CHI;
					end
					fcs_pkg::PH_PAY: begin
						if (seen_q == 6'd0) begin
							first_q <= rx_byte;
						end
						seen_q <= seen_nxt;
						crc_q  <= crc_nxt;
						if (seen_nxt == flen_q) begin
							phase_q <= fcs_pkg::PH_CHI;
						end
					end
					fcs_pkg::PH_CHI: begin
						chk_hi_q <= rx_byte;
						phase_q  <= fcs_pkg::PH_CLO;
					end
					fcs_pkg::PH_CLO: begin
						phase_q <= fcs_pkg::PH_HUNT;
						if ({chk_hi_q, rx_byte} != crc_q) begin
							bad_cnt_q <= bad_cnt_q + 16'd1;
						end else begin
							pend_q <= 1'b1;
							idx_q  <= '0;
							case (fcmd_q)
								fcs_pkg::CMD_HELLO: begin
									rcmd_q <= fcs_pkg::CMD_HELLO | fcs_pkg::RSP_BIT;
									rlen_q <= 3'd0;
								end
								fcs_pkg::CMD_READ: begin
									rcmd_q    <= fcs_pkg::CMD_READ | fcs_pkg::RSP_BIT;
									rlen_q    <= 3'd2;
									rpay_q[0] <= mv[15:8];
									rpay_q[1] <= mv[7:0];
								end
								fcs_pkg::CMD_RATE: begin
									rlen_q <= 3'd1;
									if (flen_q == 6'd1) begin
										rate_q    <= first_q;
										rcmd_q    <= fcs_pkg::CMD_RATE | fcs_pkg::RSP_BIT;
										rpay_q[0] <= first_q;
									end else begin
										rcmd_q    <= fcs_pkg::NAK_CMD;
										rpay_q[0] <= fcmd_q;
									end
								end
								fcs_pkg::CMD_STATS: begin
									rcmd_q    <= fcs_pkg::CMD_STATS | fcs_pkg::RSP_BIT;
									rlen_q    <= 3'd4;
									rpay_q[0] <= bad_cnt_q[15:8];
									rpay_q[1] <= bad_cnt_q[7:0];
									rpay_q[2] <= unk_cnt_q[15:8];
									rpay_q[3] <= unk_cnt_q[7:0];
								end
								default: begin
									unk_cnt_q <= unk_cnt_q + 16'd1;
									rcmd_q    <= fcs_pkg::NAK_CMD;
									rlen_q    <= 3'd1;
									rpay_q[0] <= fcmd_q;
								end
							endcase
						end
					end
					default: begin
						phase_q <= (rx_byte == fcs_pkg::SOF_BYTE) ? fcs_pkg::PH_LEN
						                                         : fcs_pkg::PH_HUNT;
					end
				endcase
			end
			if (cmd.acc) begin
				filt_q <= filt_q + acc_rnd[47:16];
			end
			if (cmd.emit_load) begin
				pend_q <= 1'b0;
				idx_q  <= idx_q + 4'd1;
			end
			if (cmd.emit_load) begin
				tvalid_q <= 1'b1;
			end else if (m_tready) begin
				tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			tdata_q <= emit_byte;
			tlast_q <= stat.emit_last;
			if (idx_q == 4'd0) begin
				txcrc_q <= fcs_pkg::CRC_INIT;
			end else if (idx_q < pay_end) begin
				txcrc_q <= fcs_pkg::crc_step(txcrc_q, emit_byte);
			end
		end
		if (cmd.take_sample) begin
			num_q  <= {adc_mv, 4'd0};
			rem_q  <= '0;
			quot_q <= '0;
		end else if (cmd.div_fold) begin
			quot_q <= 28'(num_q[27:12]);
			rem_q  <= fold1;
		end else if (cmd.div_fix) begin
			quot_q <= num_q + quot_q + 28'(fold_hi) + 28'(fold_ge);
		end
		if (cmd.diff) begin
			diff_q <= $signed({6'd0, quot_q}) - $signed({{2{filt_q[31]}}, filt_q});
		end
		if (cmd.mul_lo) begin
			acc_q <= 52'(prod);
		end else if (cmd.mul_hi) begin
			acc_q <= acc_q + $signed({prod[34:0], 17'd0});
		end
	end

endmodule

// ----- src/fcs_chk.sv -----
// Port-level checker for the framed command station, bound to the top level.
`include "framed_command_station_macros.svh"

module fcs_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       s_tuser,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	`FCS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`FCS_ASSERT_NEXT(a_busy_after_beat, s_tvalid && s_tready, !s_tready)
	`FCS_ASSERT_NOW(a_no_input_mid_reply, m_tvalid && !m_tlast, !s_tready)
	`FCS_ASSERT_NEXT(a_sample_quiet, s_tvalid && s_tready && s_tuser, !m_tvalid || !$rose(m_tvalid))

endmodule

bind framed_command_station fcs_chk u_fcs_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ----- verif/framed_command_station_check.sv -----
// Checker for the framed command station: predicts reply bytes and compares them.
`timescale 1ns / 1ps

module framed_command_station_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic        m_tlast,
	input  logic        cfg_we,
	input  logic [16:0] cfg_wdata,
	output int          fail_count,
	output int          pending
);

	logic [16:0] alpha;
	logic [2:0]  phase;
	logic [5:0]  frame_len;
	logic [7:0]  frame_cmd;
	logic [5:0]  pay_seen;
	logic [7:0]  pay_first;
	logic [15:0] crc_run;
	logic [7:0]  crc_hi;
	logic [15:0] bad_crc_cnt;
	logic [15:0] unknown_cnt;
	logic [7:0]  rate;
	logic [31:0] ema_q16;
	logic [8:0]  reply_q[$];

	function automatic logic [15:0] crc16_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		repeat (8) r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
		return r;
	endfunction

	task automatic queue_reply(input logic [7:0] cmd, input logic [7:0] p[4], input int len);
		logic [15:0] c;
		c = crc16_byte(crc16_byte(fcs_pkg::CRC_INIT, 8'(len)), cmd);
		reply_q.push_back({1'b0, fcs_pkg::SOF_BYTE});
		reply_q.push_back({1'b0, 8'(len)});
		reply_q.push_back({1'b0, cmd});
		for (int i = 0; i < len; i++) begin
			reply_q.push_back({1'b0, p[i]});
			c = crc16_byte(c, p[i]);
		end
		reply_q.push_back({1'b0, c[15:8]});
		reply_q.push_back({1'b1, c[7:0]});
	endtask

	task automatic answer_frame();
		logic [7:0] p[4];
		longint mv;
		logic [15:0] mv16;
		p = '{default: 8'h00};
		case (frame_cmd)
			fcs_pkg::CMD_HELLO: queue_reply(fcs_pkg::CMD_HELLO | fcs_pkg::RSP_BIT, p, 0);
			fcs_pkg::CMD_READ: begin
				mv = (longint'($signed(ema_q16)) + 32768) >>> 16;
				if (mv > 32767) mv = 32767;
				if (mv < -32768) mv = -32768;
				mv16 = mv[15:0];
				p[0] = mv16[15:8];
				p[1] = mv16[7:0];
				queue_reply(fcs_pkg::CMD_READ | fcs_pkg::RSP_BIT, p, 2);
			end
			fcs_pkg::CMD_RATE: begin
				if (frame_len != 6'd1) begin
					p[0] = frame_cmd;
					queue_reply(fcs_pkg::NAK_CMD, p, 1);
				end else begin
					rate = pay_first;
					p[0] = pay_first;
					queue_reply(fcs_pkg::CMD_RATE | fcs_pkg::RSP_BIT, p, 1);
				end
			end
			fcs_pkg::CMD_STATS: begin
				p = '{bad_crc_cnt[15:8], bad_crc_cnt[7:0], unknown_cnt[15:8], unknown_cnt[7:0]};
				queue_reply(fcs_pkg::CMD_STATS | fcs_pkg::RSP_BIT, p, 4);
			end
			default: begin
				unknown_cnt++;
				p[0] = frame_cmd;
				queue_reply(fcs_pkg::NAK_CMD, p, 1);
			end
		endcase
	endtask

	task automatic parse_byte(input logic [7:0] b);
		case (phase)
			fcs_pkg::PH_LEN: begin
				if (b > fcs_pkg::MAX_PAYLOAD) begin
					phase = fcs_pkg::PH_HUNT;
				end else begin
					frame_len = b[5:0];
					pay_seen = '0;
					crc_run = crc16_byte(fcs_pkg::CRC_INIT, b);
					phase = fcs_pkg::PH_CMD;
				end
			end
			fcs_pkg::PH_CMD: begin
				frame_cmd = b;
				crc_run = crc16_byte(crc_run, b);
				phase = (frame_len != 0) ? fcs_pkg::PH_PAY : fcs_pkg::PH_CHI;
			end
			fcs_pkg::PH_PAY: begin
				if (pay_seen == 0) pay_first = b;
				pay_seen++;
				crc_run = crc16_byte(crc_run, b);
				if (pay_seen == frame_len) phase = fcs_pkg::PH_CHI;
			end
			fcs_pkg::PH_CHI: begin
				crc_hi = b;
				phase = fcs_pkg::PH_CLO;
			end
			fcs_pkg::PH_CLO: begin
				phase = fcs_pkg::PH_HUNT;
				if ({crc_hi, b} != crc_run) bad_crc_cnt++;
				else answer_frame();
			end
			default: phase = (b == fcs_pkg::SOF_BYTE) ? fcs_pkg::PH_LEN : fcs_pkg::PH_HUNT;
		endcase
	endtask

	task automatic filter_sample(input logic [11:0] raw);
		longint x;
		longint y;
		longint prod;
		longint step;
		x = ((longint'(raw) * 3300) <<< 16) / 4095;
		y = longint'($signed(ema_q16));
		prod = longint'(alpha) * (x - y);
		step = (prod + 32768) >>> 16;
		ema_q16 = ema_q16 + step[31:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha = fcs_pkg::ALPHA_RST;
			phase = fcs_pkg::PH_HUNT;
			frame_len = '0;
			frame_cmd = '0;
			pay_seen = '0;
			pay_first = '0;
			crc_run = '0;
			crc_hi = '0;
			bad_crc_cnt = '0;
			unknown_cnt = '0;
			rate = fcs_pkg::RATE_RST;
			ema_q16 = '0;
			reply_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_we) alpha = cfg_wdata;
			if (s_tvalid && s_tready) begin
				if (s_tuser) filter_sample(s_tdata[19:8]);
				else parse_byte(s_tdata[7:0]);
			end
			if (m_tvalid && m_tready) begin
				if (reply_q.size() == 0) begin
					$display("%0t unexpected reply beat: expected none actual %h last %b",
						$time, m_tdata, m_tlast);
					fail_count++;
				end else begin
					logic [8:0] want;
					want = reply_q.pop_front();
					if (want != {m_tlast, m_tdata}) begin
						$display("%0t reply mismatch: expected %h last %b actual %h last %b",
							$time, want[7:0], want[8], m_tdata, m_tlast);
						fail_count++;
					end
				end
			end
			pending = reply_q.size();
		end
	end

endmodule

// ----- verif/framed_command_station_test.sv -----
// Testbench top for the framed command station: stimulus, idling and verdict.
`timescale 1ns / 1ps

module framed_command_station_test;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // rx_byte[7:0], adc_sample[19:8], zero[23:20]
	logic        s_tuser;   // req_type
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // tx_byte[7:0]
	logic        m_tlast;
	logic        cfg_we;
	logic [16:0] cfg_wdata;
	int          fail_count;
	int          pending;
	bit          steady;
	int          hold_req;
	int          hold_done;
	int          quiet_cycles;
	int          beats;

	framed_command_station u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	framed_command_station_check u_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		m_tready <= 0;
		hold_done = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_done) begin
				m_tready <= 0;
				repeat (300) @(posedge clk);
				hold_done = hold_req;
			end
			m_tready <= steady || ($urandom_range(99) >= 37);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic put_beat(input bit is_sample, input logic [7:0] b, input logic [11:0] smp);
		while (!steady && $urandom_range(99) < 37) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= is_sample;
		s_tdata <= {4'h0, smp, b};
		do @(posedge clk); while (!s_tready);
		beats++;
	endtask

	task automatic put_byte(input logic [7:0] b);
		put_beat(1'b0, b, 12'($urandom_range(4095)));
	endtask

	task automatic put_sample(input logic [11:0] smp);
		put_beat(1'b1, 8'($urandom_range(255)), smp);
	endtask

	task automatic put_frame(input int len, input logic [7:0] cmd, input bit corrupt);
		logic [15:0] c;
		logic [7:0] b;
		put_byte(fcs_pkg::SOF_BYTE);
		put_byte(8'(len));
		c = u_check.crc16_byte(fcs_pkg::CRC_INIT, 8'(len));
		put_byte(cmd);
		c = u_check.crc16_byte(c, cmd);
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom_range(255));
			put_byte(b);
			c = u_check.crc16_byte(c, b);
		end
		if (corrupt) c ^= 16'(1 << $urandom_range(15));
		put_byte(c[15:8]);
		put_byte(c[7:0]);
	endtask

	task automatic settle();
		s_tvalid <= 0;
		wait (pending == 0);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_alpha(input logic [16:0] v);
		settle();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic random_item();
		int pick;
		int len;
		logic [7:0] cmd;
		pick = $urandom_range(99);
		if (pick < 20) begin
			put_sample(12'($urandom_range(4095)));
		end else if (pick < 25) begin
			put_byte(8'($urandom_range(255)));
		end else if (pick < 28) begin
			put_byte(fcs_pkg::SOF_BYTE);
			put_byte(8'($urandom_range(255, 33)));
		end else begin
			pick = $urandom_range(5);
			cmd = (pick == 5) ? 8'($urandom_range(255)) : 8'(pick);
			len = ($urandom_range(9) == 0) ? $urandom_range(32) : $urandom_range(4);
			if (cmd == fcs_pkg::CMD_RATE && $urandom_range(3) != 0) len = 1;
			put_frame(len, cmd, $urandom_range(9) == 0);
		end
	endtask

	initial begin
		arst_n = 0;
		s_tvalid <= 0;
		s_tuser <= 0;
		s_tdata <= '0;
		cfg_we <= 0;
		cfg_wdata <= '0;
		steady = 0;
		hold_req = 0;
		beats = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		put_byte(8'h00);
		put_byte(8'hFF);
		put_frame(0, fcs_pkg::CMD_HELLO, 0);
		put_sample(12'd4095);
		put_sample(12'd0);
		put_sample(12'd4095);
		put_frame(0, fcs_pkg::CMD_READ, 0);
		put_frame(1, fcs_pkg::CMD_RATE, 0);
		put_frame(0, fcs_pkg::CMD_RATE, 0);
		put_frame(2, fcs_pkg::CMD_RATE, 0);
		put_frame(0, 8'h00, 0);
		put_frame(32, 8'hFF, 0);
		put_frame(3, fcs_pkg::CMD_HELLO, 1);
		put_byte(fcs_pkg::SOF_BYTE);
		put_byte(8'd33);
		put_byte(fcs_pkg::SOF_BYTE);
		put_byte(8'hFF);
		put_frame(0, fcs_pkg::CMD_STATS, 0);

		write_alpha(17'd65536);
		put_sample(12'd4095);
		put_frame(0, fcs_pkg::CMD_READ, 0);
		write_alpha(17'h1FFFF);
		repeat (6) put_sample(12'($urandom_range(4095)));
		put_frame(0, fcs_pkg::CMD_READ, 0);
		write_alpha(17'd0);
		put_sample(12'd2048);
		put_frame(0, fcs_pkg::CMD_READ, 0);
		write_alpha(17'($urandom_range(65536)));

		hold_req = 1;
		repeat (6) put_frame($urandom_range(4), 8'($urandom_range(5)), 0);
		settle();

		steady = 1;
		while (beats < 240) random_item();
		steady = 0;
		write_alpha(17'($urandom_range(131071)));
		while (beats < 330) random_item();
		write_alpha(17'($urandom_range(65536)));
		while (beats < 405) random_item();
		put_frame(0, fcs_pkg::CMD_STATS, 0);

		settle();
		if (fail_count == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule
